// ===== hdl/pts_pkg.sv =====
// Shared types, operation codes and controller/datapath interface for the task scheduler.
package pts_pkg;

    // Input item as carried on the s_ channel
    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  task_id;
        logic [4:0]  priority_req;
        logic [31:0] delay_ticks;
        logic        waits_event;
    } pts_in_t;

    // Result item as carried on the m_ channel
    typedef struct packed {
        logic       kind;
        logic [3:0] result_task;
        logic       switch_now;
        logic       none_ready;
        logic [7:0] lock_level;
        logic       last;
    } pts_out_t;

    // Operation codes
    localparam logic [3:0] FUNC_READY    = 4'd0;
    localparam logic [3:0] FUNC_UNREADY  = 4'd1;
    localparam logic [3:0] FUNC_DELAY    = 4'd2;
    localparam logic [3:0] FUNC_WAKE     = 4'd3;
    localparam logic [3:0] FUNC_DROP     = 4'd4;
    localparam logic [3:0] FUNC_TICK     = 4'd5;
    localparam logic [3:0] FUNC_LOCK     = 4'd6;
    localparam logic [3:0] FUNC_UNLOCK   = 4'd7;
    localparam logic [3:0] FUNC_SCHEDULE = 4'd8;

    // Result kinds
    localparam logic KIND_NOTICE   = 1'b0;
    localparam logic KIND_DECISION = 1'b1;

    localparam logic [7:0] LOCK_MAX    = 8'd255;
    localparam logic [7:0] SLICE_RESET = 8'd10;

    // Datapath micro-commands
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LATCH,
        CMD_RM_FIRST,
        CMD_RM_WALK,
        CMD_MAKE_READY,
        CMD_PUSH_BACK,
        CMD_DELAY,
        CMD_DROP,
        CMD_LOCK,
        CMD_UNLOCK,
        CMD_TICK_SCAN,
        CMD_TICK_EXPIRE,
        CMD_TICK_SLICE,
        CMD_DECIDE
    } pts_cmd_t;

    typedef struct packed {
        pts_cmd_t cmd;
        logic     sched;
    } pts_ctl_t;

    typedef struct packed {
        logic [3:0] func;
        logic       task_ok;
        logic       rm_first_done;
        logic       rm_walk_done;
        logic       scan_more;
        logic       scan_expire;
        logic       exp_event;
        logic       cur_valid;
        logic       slice_expire;
        logic       cur_ready;
        logic       lock_one;
        logic       out_free;
    } pts_stat_t;

endpackage

// ===== hdl/priority_task_scheduler.sv =====
// Priority task scheduler top level: controller plus datapath.
//
// Items arrive on the s_ valid/ready channel, one at a time; results leave on
// the m_ valid/ready channel through a one-entry output register. Every item
// ends with one decision (last = 1); a tick first gives one timeout notice per
// expired event waiter, in delay queue order.
// Lock, unlock, schedule, delay, wake and drop pass from dispatch straight
// to the decision; ready and unready first walk the task's priority queue to
// remove the task, and ready then puts it at the head of its new queue. A
// tick scans the delay queue, makes each expired task ready after its notice,
// then runs the slice step, which may move the current task to the back of
// its queue, before the decision. Scan and walk advance one step per cycle.
// The next item is taken once the decision is written to the output register,
// while that result may still wait for m_ready. A stalled receiver holds the
// block in the state that produces the next result.
// Reset (aresetn low, synchronous) empties all queues, clears the lock count
// and current task and loads time_slice with 10; cfg_wr_en writes time_slice.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int PRIO_COUNT = 32,
    parameter int MAX_TASKS  = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  pts_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pts_out_t   m_data
);

    pts_ctl_t  ctl;
    pts_stat_t stat;

    // Sequencer
    pts_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Queues, counters and result register
    pts_datapath #(
        .PRIO_COUNT (PRIO_COUNT),
        .MAX_TASKS  (MAX_TASKS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .ctl         (ctl),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== hdl/pts_datapath.sv =====
// Scheduler datapath: ready queues, delay queue, slices, lock and result register.
module pts_datapath
    import pts_pkg::*;
#(
    parameter int PRIO_COUNT = 32,
    parameter int MAX_TASKS  = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  pts_in_t    s_data,
    input  pts_ctl_t   ctl,
    output pts_stat_t  stat,
    output logic       m_valid,
    input  logic       m_ready,
    output pts_out_t   m_data
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PW = (PRIO_COUNT > 1) ? $clog2(PRIO_COUNT) : 1;
    localparam int FW = $clog2(MAX_TASKS + 1);

    // Scheduler state
    logic [7:0]            time_slice_reg;
    logic [PRIO_COUNT-1:0] bitmap_reg;
    logic [TW-1:0]         head_reg  [PRIO_COUNT];
    logic [TW-1:0]         tail_reg  [PRIO_COUNT];
    logic [TW-1:0]         next_reg  [MAX_TASKS];
    logic [PW-1:0]         prio_reg  [MAX_TASKS];
    logic [31:0]           count_reg [MAX_TASKS];
    logic [TW-1:0]         order_reg [MAX_TASKS];
    logic [7:0]            slice_reg [MAX_TASKS];
    logic [FW-1:0]         fill_reg;
    logic [MAX_TASKS-1:0]  rmark_reg;
    logic [MAX_TASKS-1:0]  ev_reg;
    logic [MAX_TASKS-1:0]  sv_reg;
    logic [7:0]            lock_reg;
    logic [TW-1:0]         cur_reg;
    logic                  curv_reg;

    // Working registers of the current item
    logic [3:0]    func_reg;
    logic          task_ok_reg;
    logic [TW-1:0] wt_reg;
    logic [PW-1:0] np_reg;
    logic [31:0]   ticks_reg;
    logic          evin_reg;
    logic [PW-1:0] wp_reg;
    logic [TW-1:0] nt_reg;
    logic [TW-1:0] prev_reg;
    logic [FW-1:0] walk_reg;
    logic [FW-1:0] idx_reg;

    logic     m_valid_reg;
    pts_out_t m_data_reg;

    // Combinational reads
    logic [PW-1:0] wt_prio;
    logic [TW-1:0] wt_next;
    logic [TW-1:0] rm_head;
    logic [TW-1:0] rm_tail;
    logic          rm_bm;
    logic [TW-1:0] walk_next;
    logic [TW-1:0] wp_tail;
    logic [TW-1:0] mr_head;
    logic          mr_bm;
    logic [TW-1:0] scan_idx;
    logic [TW-1:0] scan_task;
    logic [31:0]   scan_cnt;
    logic [7:0]    cur_slice;
    logic          hit_found;
    logic [TW-1:0] hit_pos;
    logic [TW-1:0] cmp_pos;
    logic          dec_any;
    logic [PW-1:0] dec_p;
    logic [TW-1:0] dec_task;
    logic          dec_switch;
    logic          out_free;

    assign wt_prio   = prio_reg[wt_reg];
    assign wt_next   = next_reg[wt_reg];
    assign rm_head   = head_reg[wt_prio];
    assign rm_tail   = tail_reg[wt_prio];
    assign rm_bm     = bitmap_reg[wt_prio];
    assign walk_next = next_reg[prev_reg];
    assign wp_tail   = tail_reg[wp_reg];
    assign mr_head   = head_reg[np_reg];
    assign mr_bm     = bitmap_reg[np_reg];
    assign scan_idx  = idx_reg[TW-1:0];
    assign scan_task = order_reg[scan_idx];
    assign scan_cnt  = count_reg[scan_task] - 32'd1;
    assign cur_slice = slice_reg[cur_reg];
    assign out_free  = !m_valid_reg || m_ready;

    // First delay queue position holding the working task
    always_comb begin
        hit_found = 1'b0;
        hit_pos   = '0;
        for (int j = MAX_TASKS - 1; j >= 0; j--) begin
            if (order_reg[j] == wt_reg && FW'(j) < fill_reg) begin
                hit_found = 1'b1;
                hit_pos   = TW'(j);
            end
        end
    end

    assign cmp_pos = (ctl.cmd == CMD_DROP) ? hit_pos : scan_idx;

    // Highest priority ready queue
    always_comb begin
        dec_any = 1'b0;
        dec_p   = '0;
        for (int p = PRIO_COUNT - 1; p >= 0; p--) begin
            if (bitmap_reg[p]) begin
                dec_any = 1'b1;
                dec_p   = PW'(p);
            end
        end
    end

    assign dec_task   = head_reg[dec_p];
    assign dec_switch = ctl.sched && lock_reg == 8'd0 && dec_any &&
                        (!curv_reg || dec_task != cur_reg);

    // Status to the controller
    always_comb begin
        stat.func          = func_reg;
        stat.task_ok       = task_ok_reg;
        stat.rm_first_done = !rmark_reg[wt_reg] || !rm_bm || rm_head == wt_reg;
        stat.rm_walk_done  = prev_reg == wp_tail || walk_next == wt_reg ||
                             walk_reg == FW'(MAX_TASKS - 1);
        stat.scan_more     = idx_reg < fill_reg;
        stat.scan_expire   = scan_cnt == 32'd0;
        stat.exp_event     = ev_reg[wt_reg];
        stat.cur_valid     = curv_reg;
        stat.slice_expire  = cur_slice <= 8'd1;
        stat.cur_ready     = rmark_reg[cur_reg];
        stat.lock_one      = lock_reg == 8'd1;
        stat.out_free      = out_free;
    end

    // State update per command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_slice_reg <= SLICE_RESET;
            bitmap_reg     <= '0;
            fill_reg       <= '0;
            rmark_reg      <= '0;
            ev_reg         <= '0;
            sv_reg         <= '0;
            lock_reg       <= '0;
            curv_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                time_slice_reg <= cfg_wr_data;
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (ctl.cmd)
                CMD_LATCH: begin
                    func_reg    <= s_data.func;
                    task_ok_reg <= 32'(s_data.task_id) < MAX_TASKS;
                    wt_reg      <= TW'(s_data.task_id);
                    np_reg      <= (32'(s_data.priority_req) >= PRIO_COUNT) ?
                                   PW'(PRIO_COUNT - 1) : PW'(s_data.priority_req);
                    ticks_reg   <= s_data.delay_ticks;
                    evin_reg    <= s_data.waits_event;
                    idx_reg     <= '0;
                end
                CMD_RM_FIRST: begin
                    wp_reg   <= wt_prio;
                    nt_reg   <= wt_next;
                    prev_reg <= rm_head;
                    walk_reg <= '0;
                    if (rmark_reg[wt_reg]) begin
                        rmark_reg[wt_reg] <= 1'b0;
                        if (rm_bm && rm_head == wt_reg) begin
                            if (rm_tail == wt_reg) begin
                                bitmap_reg[wt_prio] <= 1'b0;
                            end else begin
                                head_reg[wt_prio] <= wt_next;
                            end
                        end
                    end
                end
                CMD_RM_WALK: begin
                    walk_reg <= walk_reg + FW'(1);
                    if (prev_reg != wp_tail) begin
                        if (walk_next == wt_reg) begin
                            next_reg[prev_reg] <= nt_reg;
                            if (wp_tail == wt_reg) begin
                                tail_reg[wp_reg] <= prev_reg;
                            end
                        end else begin
                            prev_reg <= walk_next;
                        end
                    end
                end
                CMD_MAKE_READY: begin
                    prio_reg[wt_reg] <= np_reg;
                    if (mr_bm) begin
                        next_reg[wt_reg] <= mr_head;
                    end else begin
                        tail_reg[np_reg]   <= wt_reg;
                        bitmap_reg[np_reg] <= 1'b1;
                    end
                    head_reg[np_reg]  <= wt_reg;
                    rmark_reg[wt_reg] <= 1'b1;
                    if (!sv_reg[wt_reg]) begin
                        slice_reg[wt_reg] <= time_slice_reg;
                        sv_reg[wt_reg]    <= 1'b1;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (rm_bm) begin
                        next_reg[rm_tail] <= wt_reg;
                        tail_reg[wt_prio] <= wt_reg;
                    end else begin
                        head_reg[wt_prio]   <= wt_reg;
                        tail_reg[wt_prio]   <= wt_reg;
                        bitmap_reg[wt_prio] <= 1'b1;
                    end
                    rmark_reg[wt_reg] <= 1'b1;
                end
                CMD_DELAY: begin
                    count_reg[wt_reg] <= ticks_reg;
                    ev_reg[wt_reg]    <= evin_reg;
                    if (!hit_found && fill_reg < FW'(MAX_TASKS)) begin
                        order_reg[fill_reg[TW-1:0]] <= wt_reg;
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
                CMD_DROP: begin
                    if (hit_found) begin
                        for (int j = 0; j < MAX_TASKS - 1; j++) begin
                            if (TW'(j) >= cmp_pos) begin
                                order_reg[j] <= order_reg[j+1];
                            end
                        end
                        fill_reg <= fill_reg - FW'(1);
                    end
                end
                CMD_LOCK: begin
                    if (lock_reg != LOCK_MAX) begin
                        lock_reg <= lock_reg + 8'd1;
                    end
                end
                CMD_UNLOCK: begin
                    if (lock_reg != 8'd0) begin
                        lock_reg <= lock_reg - 8'd1;
                    end
                end
                CMD_TICK_SCAN: begin
                    if (idx_reg < fill_reg) begin
                        count_reg[scan_task] <= scan_cnt;
                        if (scan_cnt == 32'd0) begin
                            wt_reg <= scan_task;
                            np_reg <= prio_reg[scan_task];
                        end else begin
                            idx_reg <= idx_reg + FW'(1);
                        end
                    end
                end
                CMD_TICK_EXPIRE: begin
                    // timeout notice for an event waiter, then leave the delay queue
                    if (ev_reg[wt_reg]) begin
                        ev_reg[wt_reg]         <= 1'b0;
                        m_valid_reg            <= 1'b1;
                        m_data_reg.kind        <= KIND_NOTICE;
                        m_data_reg.result_task <= 4'(wt_reg);
                        m_data_reg.switch_now  <= 1'b0;
                        m_data_reg.none_ready  <= 1'b0;
                        m_data_reg.lock_level  <= lock_reg;
                        m_data_reg.last        <= 1'b0;
                    end
                    for (int j = 0; j < MAX_TASKS - 1; j++) begin
                        if (TW'(j) >= cmp_pos) begin
                            order_reg[j] <= order_reg[j+1];
                        end
                    end
                    fill_reg <= fill_reg - FW'(1);
                end
                CMD_TICK_SLICE: begin
                    wt_reg <= cur_reg;
                    if (curv_reg) begin
                        if (cur_slice <= 8'd1) begin
                            slice_reg[cur_reg] <= time_slice_reg;
                        end else begin
                            slice_reg[cur_reg] <= cur_slice - 8'd1;
                        end
                    end
                end
                CMD_DECIDE: begin
                    if (dec_switch) begin
                        cur_reg  <= dec_task;
                        curv_reg <= 1'b1;
                    end
                    m_valid_reg            <= 1'b1;
                    m_data_reg.kind        <= KIND_DECISION;
                    m_data_reg.result_task <= dec_any ? 4'(dec_task) : 4'd0;
                    m_data_reg.switch_now  <= dec_switch;
                    m_data_reg.none_ready  <= !dec_any;
                    m_data_reg.lock_level  <= lock_reg;
                    m_data_reg.last        <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/pts_controller.sv =====
// Scheduler controller: sequences the datapath through one operation at a time.
module pts_controller
    import pts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pts_stat_t stat,
    output pts_ctl_t  ctl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RM_FIRST,
        ST_RM_WALK,
        ST_MAKE_READY,
        ST_PUSH_BACK,
        ST_TICK_SCAN,
        ST_TICK_EXPIRE,
        ST_TICK_SLICE,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   sched_reg, sched_next;
    logic   rot_reg, rot_next;
    state_t after_rm;

    // Where a finished queue removal continues
    always_comb begin
        if (stat.func == FUNC_UNREADY) begin
            after_rm = ST_DECIDE;
        end else if (stat.func == FUNC_TICK && rot_reg) begin
            after_rm = ST_PUSH_BACK;
        end else begin
            after_rm = ST_MAKE_READY;
        end
    end

    // Next state and command
    always_comb begin
        state_next = state_reg;
        sched_next = sched_reg;
        rot_next   = rot_reg;
        ctl.cmd    = CMD_IDLE;
        ctl.sched  = sched_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.cmd    = CMD_LATCH;
                    sched_next = 1'b0;
                    rot_next   = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_DECIDE;
                unique case (stat.func) inside
                    FUNC_READY, FUNC_UNREADY: begin
                        if (stat.task_ok) begin
                            state_next = ST_RM_FIRST;
                        end
                    end
                    FUNC_DELAY: begin
                        if (stat.task_ok) begin
                            ctl.cmd = CMD_DELAY;
                        end
                    end
                    FUNC_WAKE, FUNC_DROP: begin
                        if (stat.task_ok) begin
                            ctl.cmd = CMD_DROP;
                        end
                    end
                    FUNC_TICK: begin
                        sched_next = 1'b1;
                        state_next = ST_TICK_SCAN;
                    end
                    FUNC_LOCK: begin
                        ctl.cmd = CMD_LOCK;
                    end
                    FUNC_UNLOCK: begin
                        ctl.cmd    = CMD_UNLOCK;
                        sched_next = stat.lock_one;
                    end
                    FUNC_SCHEDULE: begin
                        sched_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RM_FIRST: begin
                ctl.cmd    = CMD_RM_FIRST;
                state_next = stat.rm_first_done ? after_rm : ST_RM_WALK;
            end
            ST_RM_WALK: begin
                ctl.cmd = CMD_RM_WALK;
                if (stat.rm_walk_done) begin
                    state_next = after_rm;
                end
            end
            ST_MAKE_READY: begin
                ctl.cmd    = CMD_MAKE_READY;
                state_next = (stat.func == FUNC_TICK) ? ST_TICK_SCAN : ST_DECIDE;
            end
            ST_PUSH_BACK: begin
                ctl.cmd    = CMD_PUSH_BACK;
                state_next = ST_DECIDE;
            end
            ST_TICK_SCAN: begin
                ctl.cmd = CMD_TICK_SCAN;
                if (!stat.scan_more) begin
                    state_next = ST_TICK_SLICE;
                end else if (stat.scan_expire) begin
                    state_next = ST_TICK_EXPIRE;
                end
            end
            ST_TICK_EXPIRE: begin
                // a notice needs the result register free
                if (!stat.exp_event || stat.out_free) begin
                    ctl.cmd    = CMD_TICK_EXPIRE;
                    state_next = ST_RM_FIRST;
                end
            end
            ST_TICK_SLICE: begin
                ctl.cmd = CMD_TICK_SLICE;
                if (stat.cur_valid && stat.slice_expire && stat.cur_ready) begin
                    rot_next   = 1'b1;
                    state_next = ST_RM_FIRST;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.out_free) begin
                    ctl.cmd    = CMD_DECIDE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sched_reg <= 1'b0;
            rot_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sched_reg <= sched_next;
            rot_reg   <= rot_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== hdl/pts_checker.sv =====
// Port-level checks for the task scheduler, bound to the top level.
module pts_checker
    import pts_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input pts_out_t m_data
);

    // No result right after reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One item at a time: no acceptance in the cycle after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Notices never switch and never end an item
    a_notice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_NOTICE |->
        !m_data.switch_now && !m_data.none_ready && !m_data.last)
        else $error("malformed timeout notice");

    // Decisions end the item and never switch to nothing
    a_decision: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_DECISION |->
        m_data.last && !(m_data.none_ready && m_data.switch_now))
        else $error("malformed decision");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
